/* rtl/gtg_pkg.sv */
// Shared types, constants and the arctangent table for the go-to-goal controller.
package gtg_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_TARGET_X     = 2'd0;
	localparam logic [1:0] REG_TARGET_Y     = 2'd1;
	localparam logic [1:0] REG_LINEAR_GAIN  = 2'd2;
	localparam logic [1:0] REG_ANGULAR_GAIN = 2'd3;

	// Register reset values.
	localparam logic [15:0] TARGET_X_RST     = 16'd4096;
	localparam logic [15:0] TARGET_Y_RST     = 16'd4096;
	localparam logic [15:0] LINEAR_GAIN_RST  = 16'd819;
	localparam logic [15:0] ANGULAR_GAIN_RST = 16'd4096;

	// Key codes that override a command.
	localparam logic [7:0] KEY_FWD   = 8'd119;
	localparam logic [7:0] KEY_BACK  = 8'd120;
	localparam logic [7:0] KEY_LEFT  = 8'd97;
	localparam logic [7:0] KEY_RIGHT = 8'd100;

	// Override magnitude, 3.0 in Q5.11.
	localparam logic signed [15:0] CMD_THREE = 16'sd6144;

	// Datapath widths: CORDIC x and y in Q23, angle in radians Q24.
	localparam int XW = 32;
	localparam int ZW = 29;

	// Inverse CORDIC gain in Q0.16 and pi in Q24.
	localparam logic [15:0] INV_K_Q16 = 16'd39797;
	localparam logic signed [ZW-1:0] PI_Q24 = 29'sd52707179;

	// atan(2^-i) in radians Q24.
	localparam int ATAN_LEN = 20;
	localparam logic [23:0] ATAN_Q24 [ATAN_LEN] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
		24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
		24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024,
		24'd512, 24'd256, 24'd128, 24'd64, 24'd32
	};

	// Side information that rides along with each transaction through the CORDIC.
	typedef struct packed {
		logic              zero;
		logic signed [15:0] heading;
		logic [7:0]        key;
	} side_t;

endpackage

/* rtl/go_to_goal_p_controller_unit.sv */
// Top level of the go-to-goal proportional controller for a unicycle robot.
//
// Usage: raise start with a pose (pose_x, pose_y, pose_heading) and a key_code;
// the transaction is taken at the rising edge where start is high and busy is
// low. busy is always low, so a new pose may be given in every cycle.
// Each transaction yields one result: done is high for exactly one cycle while
// linear_velocity and angular_velocity hold the commands. The receiver cannot
// stall; it must take the result in that cycle.
// After acceptance, registered steps in order form the position error, then one
// per CORDIC iteration, then scaling by 1/K, the gain multiplies, and rounding
// with saturation and key override. Throughput is one transaction per cycle,
// set by the unrolled CORDIC pipeline.
// Configuration (target_x, target_y, linear_gain, angular_gain) must be written
// by the user through cfg_we/cfg_index/cfg_data while no transaction is in
// flight; the block itself does not enforce this.
// Reset clears all in-flight transactions and restores the register defaults:
// target (2.0, 2.0), linear gain 0.2, angular gain 1.0.
module go_to_goal_p_controller_unit #(
	parameter int CORDIC_STAGES = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic [7:0]         key_code,
	output logic               done,
	output logic signed [15:0] linear_velocity,
	output logic signed [15:0] angular_velocity,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import gtg_pkg::*;

	logic signed [15:0] target_x_q;
	logic signed [15:0] target_y_q;
	logic [15:0]        linear_gain_q;
	logic [15:0]        angular_gain_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q     <= TARGET_X_RST;
			target_y_q     <= TARGET_Y_RST;
			linear_gain_q  <= LINEAR_GAIN_RST;
			angular_gain_q <= ANGULAR_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_X:     target_x_q     <= cfg_data;
				REG_TARGET_Y:     target_y_q     <= cfg_data;
				REG_LINEAR_GAIN:  linear_gain_q  <= cfg_data;
				REG_ANGULAR_GAIN: angular_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline never holds off a transaction.
	assign busy = 1'b0;

	// Stage 1: position error, left-half-plane fold and initial angle.
	logic signed [16:0]   ex;
	logic signed [16:0]   ey;
	logic signed [XW-1:0] ex_w;
	logic signed [XW-1:0] ey_w;
	logic                 v_s1;
	logic signed [XW-1:0] x_s1;
	logic signed [XW-1:0] y_s1;
	logic signed [ZW-1:0] z_s1;
	side_t                side_s1;

	always_comb begin
		ex   = 17'(target_x_q) - 17'(pose_x);
		ey   = 17'(target_y_q) - 17'(pose_y);
		ex_w = XW'(ex) <<< 12;
		ey_w = XW'(ey) <<< 12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.zero    <= (ex == 17'sd0) && (ey == 17'sd0);
		side_s1.heading <= pose_heading;
		side_s1.key     <= key_code;
		if (ex < 0) begin
			x_s1 <= -ex_w;
			y_s1 <= -ey_w;
			z_s1 <= (ey >= 0) ? PI_Q24 : -PI_Q24;
		end else begin
			x_s1 <= ex_w;
			y_s1 <= ey_w;
			z_s1 <= '0;
		end
	end

	// CORDIC stages: distance (times K) and bearing.
	logic                 cv;
	logic signed [XW-1:0] cx;
	logic signed [ZW-1:0] cz;
	side_t                cside;

	gtg_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_x     (x_s1),
		.in_y     (y_s1),
		.in_z     (z_s1),
		.in_side  (side_s1),
		.out_valid(cv),
		.out_x    (cx),
		.out_z    (cz),
		.out_side (cside)
	);

	// Scale stage: remove the CORDIC gain and form the heading error.
	logic [46:0]        dprod;
	logic [46:0]        dsum;
	logic signed [29:0] aerr;
	logic               v_s2;
	logic [17:0]        dist_s2;
	logic signed [29:0] aerr_s2;
	logic [7:0]         key_s2;

	always_comb begin
		// x is never negative after the fold, so the product is taken unsigned.
		dprod = 47'(cx[XW-2:0]) * 47'(INV_K_Q16);
		dsum  = dprod + 47'(1 << 27);
		if (cside.zero) begin
			aerr = -(30'(cside.heading) <<< 11);
		end else begin
			aerr = 30'(cz) - (30'(cside.heading) <<< 11);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= cv;
		end
	end

	always_ff @(posedge clk) begin
		dist_s2 <= cside.zero ? '0 : 18'(dsum >> 28);
		aerr_s2 <= aerr;
		key_s2  <= cside.key;
	end

	// Gain stage: proportional products.
	logic               v_s3;
	logic [33:0]        lprod_s3;
	logic signed [46:0] aprod_s3;
	logic [7:0]         key_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		lprod_s3 <= 34'(dist_s2) * 34'(linear_gain_q);
		aprod_s3 <= 47'(aerr_s2) * $signed({31'b0, angular_gain_q});
		key_s3   <= key_s2;
	end

	// Output stage: round half up, saturate, then apply key overrides.
	logic [33:0]        lsum;
	logic [21:0]        lrnd;
	logic signed [46:0] asum;
	logic signed [21:0] arnd;
	logic signed [15:0] lin;
	logic signed [15:0] ang;
	logic               done_q;
	logic signed [15:0] lin_q;
	logic signed [15:0] ang_q;

	always_comb begin
		lsum = lprod_s3 + 34'd2048;
		lrnd = 22'(lsum >> 12);
		asum = aprod_s3 + 47'sd16777216;
		arnd = 22'(asum >>> 25);
		lin  = (lrnd > 22'd32767) ? 16'sd32767 : 16'(lrnd);
		if (arnd > 22'sd32767) begin
			ang = 16'sd32767;
		end else if (arnd < -22'sd32768) begin
			ang = -16'sd32768;
		end else begin
			ang = 16'(arnd);
		end
		if (key_s3 == KEY_FWD) begin
			lin = CMD_THREE;
		end else if (key_s3 == KEY_BACK) begin
			lin = -CMD_THREE;
		end else if (key_s3 == KEY_LEFT) begin
			ang = CMD_THREE;
		end else if (key_s3 == KEY_RIGHT) begin
			ang = -CMD_THREE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		lin_q <= lin;
		ang_q <= ang;
	end

	assign done             = done_q;
	assign linear_velocity  = lin_q;
	assign angular_velocity = ang_q;

endmodule

/* rtl/gtg_cordic.sv */
// Unrolled, fully pipelined CORDIC in vectoring mode, one stage per iteration.
module gtg_cordic #(
	parameter int STAGES = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [gtg_pkg::XW-1:0] in_x,
	input  logic signed [gtg_pkg::XW-1:0] in_y,
	input  logic signed [gtg_pkg::ZW-1:0] in_z,
	input  gtg_pkg::side_t               in_side,
	output logic                         out_valid,
	output logic signed [gtg_pkg::XW-1:0] out_x,
	output logic signed [gtg_pkg::ZW-1:0] out_z,
	output gtg_pkg::side_t               out_side
);
	import gtg_pkg::*;

	logic                 v_s    [STAGES+1];
	logic signed [XW-1:0] x_s    [STAGES+1];
	logic signed [XW-1:0] y_s    [STAGES+1];
	logic signed [ZW-1:0] z_s    [STAGES+1];
	side_t                side_s [STAGES+1];

	// Entry of the chain.
	assign v_s[0]    = in_valid;
	assign x_s[0]    = in_x;
	assign y_s[0]    = in_y;
	assign z_s[0]    = in_z;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ANG = $signed({5'b0, ATAN_Q24[i]});

		// The valid bit travels with the data.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// One micro-rotation; arithmetic shifts floor toward minus infinity.
		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ANG;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ANG;
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_x     = x_s[STAGES];
	assign out_z     = z_s[STAGES];
	assign out_side  = side_s[STAGES];

endmodule

/* rtl/gtg_checker.sv */
// Port-level checker for the go-to-goal controller and its bind to the top level.
module gtg_checker #(
	parameter int LAT = 18
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [7:0]         key_code,
	input logic               done,
	input logic signed [15:0] linear_velocity,
	input logic signed [15:0] angular_velocity
);
	import gtg_pkg::*;

	// Every accepted transaction produces exactly one result after the latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	// No result appears without a transaction accepted at the matching time.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted transaction");

	// Forward key forces the linear command to +3.0.
	a_key_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && key_code == KEY_FWD, LAT))
		|-> linear_velocity == CMD_THREE)
		else $error("forward key override missing");

	// Left key forces the angular command to +3.0.
	a_key_left: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && key_code == KEY_LEFT, LAT))
		|-> angular_velocity == CMD_THREE)
		else $error("left key override missing");

endmodule

bind go_to_goal_p_controller_unit gtg_checker #(.LAT(CORDIC_STAGES + 4)) u_gtg_checker (.*);
